// ===== design/pcd_pkg.sv =====
// shared constants, control word types and the period table of the packed track decoder
package pcd_pkg;

  localparam int ROWS         = 64;
  localparam int PERIOD_NOTES = 36;
  localparam int TABLE_LEN    = 36;
  localparam int MAX_OUT      = 64;

  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CNT_W  = $clog2(MAX_OUT + 1);
  localparam int SKIP_W = 8;
  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // sequencer operations
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_GOTO     = 3'd1;
  localparam logic [2:0] SEQ_WAIT     = 3'd2;
  localparam logic [2:0] SEQ_DISPATCH = 3'd3;
  localparam logic [2:0] SEQ_LOOP     = 3'd4;

  // datapath operations
  localparam logic [2:0] DP_NOP       = 3'd0;
  localparam logic [2:0] DP_LOAD      = 3'd1;
  localparam logic [2:0] DP_HOLD1     = 3'd2;
  localparam logic [2:0] DP_HOLD2     = 3'd3;
  localparam logic [2:0] DP_CELL      = 3'd4;
  localparam logic [2:0] DP_SKIP_INIT = 3'd5;
  localparam logic [2:0] DP_SKIP_STEP = 3'd6;

  // byte classes for the dispatch jump
  localparam logic [2:0] CLS_DONE   = 3'd0;
  localparam logic [2:0] CLS_FIRST  = 3'd1;
  localparam logic [2:0] CLS_SECOND = 3'd2;
  localparam logic [2:0] CLS_THIRD  = 3'd3;
  localparam logic [2:0] CLS_SKIP   = 3'd4;

  typedef struct packed {
    logic       accept;
    logic [2:0] seq_op;
    logic [2:0] dp_op;
    step_t      target;
  } ctrl_t;

  typedef struct packed {
    logic       stall;
    logic       skip_more;
    logic [2:0] cls;
  } stat_t;

  // standard tracker periods, note 1 first
  function automatic logic [11:0] period_lookup(input logic [5:0] note);
    logic [11:0] p;
    case (note)
      6'd1:    p = 12'd856;
      6'd2:    p = 12'd808;
      6'd3:    p = 12'd762;
      6'd4:    p = 12'd720;
      6'd5:    p = 12'd678;
      6'd6:    p = 12'd640;
      6'd7:    p = 12'd604;
      6'd8:    p = 12'd570;
      6'd9:    p = 12'd538;
      6'd10:   p = 12'd508;
      6'd11:   p = 12'd480;
      6'd12:   p = 12'd453;
      6'd13:   p = 12'd428;
      6'd14:   p = 12'd404;
      6'd15:   p = 12'd381;
      6'd16:   p = 12'd360;
      6'd17:   p = 12'd339;
      6'd18:   p = 12'd320;
      6'd19:   p = 12'd302;
      6'd20:   p = 12'd285;
      6'd21:   p = 12'd269;
      6'd22:   p = 12'd254;
      6'd23:   p = 12'd240;
      6'd24:   p = 12'd226;
      6'd25:   p = 12'd214;
      6'd26:   p = 12'd202;
      6'd27:   p = 12'd190;
      6'd28:   p = 12'd180;
      6'd29:   p = 12'd170;
      6'd30:   p = 12'd160;
      6'd31:   p = 12'd151;
      6'd32:   p = 12'd143;
      6'd33:   p = 12'd135;
      6'd34:   p = 12'd127;
      6'd35:   p = 12'd120;
      6'd36:   p = 12'd113;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/pcd_seq.sv =====
// microprogram sequencer: step counter, control rom and jump logic
module pcd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pcd_pkg::stat_t  stat,
  output pcd_pkg::ctrl_t  ctrl
);

  localparam pcd_pkg::step_t ST_FETCH     = 3'd0;
  localparam pcd_pkg::step_t ST_DISP      = 3'd1;
  localparam pcd_pkg::step_t ST_FIRST     = 3'd2;
  localparam pcd_pkg::step_t ST_SECOND    = 3'd3;
  localparam pcd_pkg::step_t ST_CELL      = 3'd4;
  localparam pcd_pkg::step_t ST_SKIP_INIT = 3'd5;
  localparam pcd_pkg::step_t ST_SKIP_STEP = 3'd6;

  pcd_pkg::step_t step;
  pcd_pkg::step_t step_next;

  // control rom
  always_comb begin
    case (step)
      ST_FETCH:     ctrl = '{1'b1, pcd_pkg::SEQ_WAIT,     pcd_pkg::DP_LOAD,      ST_DISP};
      ST_DISP:      ctrl = '{1'b0, pcd_pkg::SEQ_DISPATCH, pcd_pkg::DP_NOP,       ST_FETCH};
      ST_FIRST:     ctrl = '{1'b0, pcd_pkg::SEQ_GOTO,     pcd_pkg::DP_HOLD1,     ST_FETCH};
      ST_SECOND:    ctrl = '{1'b0, pcd_pkg::SEQ_GOTO,     pcd_pkg::DP_HOLD2,     ST_FETCH};
      ST_CELL:      ctrl = '{1'b0, pcd_pkg::SEQ_GOTO,     pcd_pkg::DP_CELL,      ST_FETCH};
      ST_SKIP_INIT: ctrl = '{1'b0, pcd_pkg::SEQ_NEXT,     pcd_pkg::DP_SKIP_INIT, ST_FETCH};
      ST_SKIP_STEP: ctrl = '{1'b0, pcd_pkg::SEQ_LOOP,     pcd_pkg::DP_SKIP_STEP, ST_SKIP_STEP};
      default:      ctrl = '{1'b0, pcd_pkg::SEQ_GOTO,     pcd_pkg::DP_NOP,       ST_FETCH};
    endcase
  end

  always_comb begin
    step_next = step;
    if (!stat.stall) begin
      case (ctrl.seq_op)
        pcd_pkg::SEQ_NEXT: step_next = step + 3'd1;
        pcd_pkg::SEQ_GOTO: step_next = ctrl.target;
        pcd_pkg::SEQ_WAIT: begin
          if (in_valid) step_next = ctrl.target;
        end
        pcd_pkg::SEQ_DISPATCH: begin
          case (stat.cls)
            pcd_pkg::CLS_FIRST:  step_next = ST_FIRST;
            pcd_pkg::CLS_SECOND: step_next = ST_SECOND;
            pcd_pkg::CLS_THIRD:  step_next = ST_CELL;
            pcd_pkg::CLS_SKIP:   step_next = ST_SKIP_INIT;
            default:             step_next = ST_FETCH;
          endcase
        end
        pcd_pkg::SEQ_LOOP: step_next = stat.skip_more ? ctrl.target : ST_FETCH;
        default:           step_next = ST_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== design/pcd_dp.sv =====
// decoder datapath: track state, cell assembly and output register
module pcd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pcd_pkg::ctrl_t       ctrl,
  output pcd_pkg::stat_t       stat,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_row,
  output logic [31:0]          out_cell,
  output logic                 out_last,
  output logic                 out_bad
);

  logic [7:0]                  b_reg;
  logic [pcd_pkg::ROW_W-1:0]   row_count;
  logic [1:0]                  byte_phase;
  logic [7:0]                  held_first;
  logic [7:0]                  held_second;
  logic                        track_done;
  logic [pcd_pkg::SKIP_W-1:0]  skip_left;
  logic [pcd_pkg::CNT_W-1:0]   emit_cnt;

  logic [pcd_pkg::ROW_W:0]     row_inc;
  logic                        row_end;
  logic                        emit_req;
  logic                        fire;
  logic                        out_load;
  logic                        stall;
  logic                        skip_more;
  logic [2:0]                  cls;
  logic                        is_last;
  logic [5:0]                  note;
  logic                        note_ok;
  logic [11:0]                 period;
  logic                        bad;
  logic [3:0]                  fx;
  logic [31:0]                 cell_word;

  assign row_inc = {1'b0, row_count} + {{pcd_pkg::ROW_W{1'b0}}, 1'b1};
  assign row_end = row_inc >= (pcd_pkg::ROW_W + 1)'(pcd_pkg::ROWS);
  assign is_last = row_count == pcd_pkg::ROW_W'(pcd_pkg::ROWS - 1);

  assign emit_req = (ctrl.dp_op == pcd_pkg::DP_CELL) ||
                    ((ctrl.dp_op == pcd_pkg::DP_SKIP_STEP) &&
                     (emit_cnt < pcd_pkg::CNT_W'(pcd_pkg::MAX_OUT)));
  assign stall     = emit_req && out_valid && !out_ready;
  assign fire      = !stall;
  assign out_load  = emit_req && fire;
  assign skip_more = (skip_left > pcd_pkg::SKIP_W'(1)) && !row_end;

  always_comb begin
    if (track_done)               cls = pcd_pkg::CLS_DONE;
    else if (byte_phase == 2'd1)  cls = pcd_pkg::CLS_SECOND;
    else if (byte_phase == 2'd2)  cls = pcd_pkg::CLS_THIRD;
    else if (b_reg[7])            cls = pcd_pkg::CLS_SKIP;
    else                          cls = pcd_pkg::CLS_FIRST;
  end

  assign stat = {stall, skip_more, cls};

  // cell assembly from the held group and the current byte
  assign note    = held_second[5:0];
  assign note_ok = (note != 6'd0) && (32'(note) <= pcd_pkg::PERIOD_NOTES) &&
                   (32'(note) <= pcd_pkg::TABLE_LEN);
  assign period  = note_ok ? pcd_pkg::period_lookup(note) : 12'd0;
  assign bad     = (note != 6'd0) && !note_ok;
  assign fx      = {held_second[7:6], held_first[6:5]};
  assign cell_word = {3'b000, held_first[4], period[11:8], period[7:0],
                      held_first[3:0], fx, b_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      byte_phase <= 2'd0;
      held_first <= 8'd0;
      held_second <= 8'd0;
      track_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (ctrl.dp_op)
        pcd_pkg::DP_LOAD: begin
          if (in_valid) begin
            b_reg <= in_byte;
            if (in_start) begin
              row_count  <= '0;
              byte_phase <= 2'd0;
              track_done <= 1'b0;
            end
          end
        end
        pcd_pkg::DP_HOLD1: begin
          held_first <= b_reg;
          byte_phase <= 2'd1;
        end
        pcd_pkg::DP_HOLD2: begin
          held_second <= b_reg;
          byte_phase  <= 2'd2;
        end
        pcd_pkg::DP_CELL: begin
          if (fire) begin
            out_row    <= row_count[5:0];
            out_cell   <= cell_word;
            out_last   <= is_last;
            out_bad    <= bad;
            byte_phase <= 2'd0;
            if (row_end) begin
              row_count  <= '0;
              track_done <= 1'b1;
            end else begin
              row_count <= row_inc[pcd_pkg::ROW_W-1:0];
            end
          end
        end
        pcd_pkg::DP_SKIP_INIT: begin
          skip_left  <= pcd_pkg::SKIP_W'({1'b0, b_reg[6:0]}) + pcd_pkg::SKIP_W'(1);
          emit_cnt   <= '0;
          byte_phase <= 2'd0;
        end
        pcd_pkg::DP_SKIP_STEP: begin
          if (fire) begin
            if (emit_req) begin
              out_row   <= row_count[5:0];
              out_cell  <= 32'd0;
              out_last  <= is_last;
              out_bad   <= 1'b0;
              emit_cnt  <= emit_cnt + pcd_pkg::CNT_W'(1);
            end
            skip_left <= skip_left - pcd_pkg::SKIP_W'(1);
            if (row_end) begin
              row_count  <= '0;
              track_done <= 1'b1;
            end else begin
              row_count <= row_inc[pcd_pkg::ROW_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/packed_track_to_cell_decoder_core.sv =====
// top level of the packed track to cell decoder
//
// channel  dir  handshake           tdata                      tuser        tlast
// s_       in   s_tvalid/s_tready   data_byte                  track_start  -
// m_       out  m_tvalid/m_tready   row, cell_res              bad_note     last
//
// a first or second byte of a group passes the fetch, dispatch and hold steps, an ignored byte only fetch and dispatch
// a third byte passes the fetch, dispatch and cell steps and emits one cell
// a skip byte passes fetch, dispatch and skip init, then loops in the skip loop step over the skipped rows
// the step counter of the microprogram sets this order of steps
// reset returns the sequencer to fetch and clears row, phase and track state
// a full output register with m_tready low holds the emitting step, input waits meanwhile
module packed_track_to_cell_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] track_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [5:0] row, [37:6] cell_res, [39:38] zero
  output logic        m_tuser,   // [0] bad_note
  output logic        m_tlast
);

  pcd_pkg::ctrl_t ctrl;
  pcd_pkg::stat_t stat;
  logic [5:0]     row;
  logic [31:0]    cell_res;

  // sequencer drives the control word for each step
  pcd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath holds track state and the output register
  pcd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_start  (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (row),
    .out_cell  (cell_res),
    .out_last  (m_tlast),
    .out_bad   (m_tuser)
  );

  // request taken only in the fetch step, never while in reset
  assign s_tready = ctrl.accept && !rst;
  assign m_tdata  = {2'b00, cell_res, row};

endmodule
